// ----- rtl/core/max_flow_widest_path_assert.svh -----
// Assertion macros used by the checker file of the max-flow block.
`ifndef MAX_FLOW_WIDEST_PATH_ASSERT_SVH
`define MAX_FLOW_WIDEST_PATH_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define MFWP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("max flow check failed");

// The consequent must hold in the same cycle as the antecedent.
`define MFWP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("max flow check failed");

`endif

// ----- rtl/core/mfwp_pkg.sv -----
package mfwp_pkg;

    localparam int FLOW_W = 22;
    localparam logic [6:0] NODE_COUNT_RST = 7'd64;
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_RUN = 1'b1;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_RANGE  = 14'b00000000000100,
        S_INIT   = 14'b00000000001000,
        S_SCAN   = 14'b00000000010000,
        S_MARK   = 14'b00000000100000,
        S_RELAX  = 14'b00000001000000,
        S_CHK_RD = 14'b00000010000000,
        S_CHK_EV = 14'b00000100000000,
        S_AUG_P  = 14'b00001000000000,
        S_AUG_PW = 14'b00010000000000,
        S_AUG_FW = 14'b00100000000000,
        S_AUG_RV = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_START,
        OP_INIT,
        OP_SCAN,
        OP_MARK,
        OP_RELAX,
        OP_CHK_RD,
        OP_CHK_EV,
        OP_AUG_P,
        OP_AUG_PW,
        OP_AUG_FW,
        OP_AUG_RV,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic iss_done;
        logic pipe_idle;
        logic found;
        logic range_ok;
        logic path_ok;
        logic aug_end;
        logic chain_ok;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/mfwp_ctrl.sv -----
module mfwp_ctrl import mfwp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_op,
    output logic       s_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OPC_RUN) begin
                        cmd.op = OP_START;
                        state_next = S_RANGE;
                    end else begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            S_RANGE: begin
                state_next = st.range_ok ? S_INIT : S_DONE;
            end
            S_INIT: begin
                cmd.op = OP_INIT;
                if (st.iss_done) state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (st.pipe_idle) state_next = st.found ? S_MARK : S_CHK_RD;
            end
            S_MARK: begin
                cmd.op = OP_MARK;
                state_next = S_RELAX;
            end
            S_RELAX: begin
                cmd.op = OP_RELAX;
                if (st.pipe_idle) state_next = S_SCAN;
            end
            S_CHK_RD: begin
                cmd.op = OP_CHK_RD;
                state_next = S_CHK_EV;
            end
            S_CHK_EV: begin
                cmd.op = OP_CHK_EV;
                state_next = st.path_ok ? S_AUG_P : S_DONE;
            end
            S_AUG_P: begin
                cmd.op = OP_AUG_P;
                state_next = st.aug_end ? S_INIT : S_AUG_PW;
            end
            S_AUG_PW: begin
                cmd.op = OP_AUG_PW;
                state_next = st.chain_ok ? S_AUG_FW : S_INIT;
            end
            S_AUG_FW: begin
                cmd.op = OP_AUG_FW;
                state_next = S_AUG_RV;
            end
            S_AUG_RV: begin
                cmd.op = OP_AUG_RV;
                state_next = S_AUG_P;
            end
            S_DONE: begin
                cmd.op = OP_EMIT;
                if (st.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/mfwp_datapath.sv -----
module mfwp_datapath import mfwp_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int CAP_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        st,
    input  logic [6:0]        node_count,
    input  logic [5:0]        s_from_node,
    input  logic [5:0]        s_to_node,
    input  logic [15:0]       s_capacity,
    input  logic [5:0]        s_source_node,
    input  logic [5:0]        s_sink_node,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [FLOW_W-1:0] m_total_flow
);

    localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = NB + 1;
    localparam int AW = 2 * NB;
    localparam int RW = CAP_BITS + 1;
    localparam int BW = CAP_BITS + 2;
    localparam int SW = ((BW > FLOW_W) ? BW : FLOW_W) + 1;
    localparam logic [RW-1:0] RES_MAX = {RW{1'b1}};
    localparam logic [BW-1:0] BN_INF = {1'b1, {RW{1'b0}}};
    localparam logic [CW-1:0] N_MAX = CW'(MAX_NODES);
    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    logic [RW-1:0] res_mem [2**AW];
    logic [BW-1:0] bn_mem [2**NB];
    logic [NB-1:0] par_mem [2**NB];
    logic          pv_mem [2**NB];
    logic          vis_mem [2**NB];

    logic [AW:0]       clr_reg, clr_next;
    dp_op_t            op_prev_reg;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [NB-1:0]     src_reg, src_next;
    logic [NB-1:0]     snk_reg, snk_next;
    logic              range_ok_reg, range_ok_next;
    logic              p1_v_reg, p1_v_next;
    logic [NB-1:0]     p1_idx_reg, p1_idx_next;
    logic              found_reg, found_next;
    logic [NB-1:0]     best_reg, best_next;
    logic [BW-1:0]     best_bn_reg, best_bn_next;
    logic [NB-1:0]     best_par_reg, best_par_next;
    logic              best_pv_reg, best_pv_next;
    logic [BW-1:0]     f_reg, f_next;
    logic [NB-1:0]     cur_reg, cur_next;
    logic [NB-1:0]     p_reg, p_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [FLOW_W-1:0] total_reg, total_next;
    logic              m_valid_reg, m_valid_next;
    logic [FLOW_W-1:0] m_flow_reg, m_flow_next;

    logic [RW-1:0] res_rd_reg;
    logic [BW-1:0] bn_rd_reg;
    logic [NB-1:0] par_rd_reg;
    logic          pv_rd_reg;
    logic          vis_rd_reg;

    logic          first;
    logic [CW-1:0] issue_idx;
    logic          iss_done;
    logic          issuing;
    logic [CW-1:0] n_eff;
    logic          load_ok;
    logic [BW-1:0] relax_w;
    logic          relax_upd;
    logic          aug_end;
    logic          out_free;
    logic [SW-1:0] flow_sum;
    logic [FLOW_W-1:0] flow_sat;
    logic [RW-1:0] fw_new;
    logic [RW-1:0] rv_new;
    logic [RW-1:0] headroom;

    logic          res_we;
    logic [AW-1:0] res_wa;
    logic [RW-1:0] res_wd;
    logic [AW-1:0] res_ra;
    logic          nd_we;
    logic [NB-1:0] nd_wa;
    logic [BW-1:0] nd_bn_wd;
    logic [NB-1:0] nd_par_wd;
    logic          nd_pv_wd;
    logic          nd_vis_wd;
    logic [NB-1:0] nd_ra;

    assign first = (cmd.op != op_prev_reg);
    assign issue_idx = first ? '0 : idx_reg;
    assign iss_done = (issue_idx == n_reg);
    assign issuing = ((cmd.op == OP_SCAN) || (cmd.op == OP_RELAX)) && !iss_done;
    assign n_eff = (int'(node_count) > MAX_NODES) ? N_MAX : CW'(node_count);
    assign load_ok = (int'(s_from_node) < MAX_NODES) && (int'(s_to_node) < MAX_NODES);
    assign relax_w = (BW'(res_rd_reg) < best_bn_reg) ? BW'(res_rd_reg) : best_bn_reg;
    assign relax_upd = !vis_rd_reg && (res_rd_reg != '0) && (bn_rd_reg < relax_w);
    assign aug_end = (cur_reg == src_reg) || (steps_reg >= n_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign flow_sum = SW'(total_reg) + SW'(f_reg);
    assign flow_sat = (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(flow_sum);
    assign fw_new = (BW'(res_rd_reg) >= f_reg) ? RW'(BW'(res_rd_reg) - f_reg) : '0;
    assign headroom = RES_MAX - res_rd_reg;
    assign rv_new = (BW'(headroom) >= f_reg) ? (res_rd_reg + RW'(f_reg)) : RES_MAX;

    assign st.clr_done = clr_reg[AW];
    assign st.iss_done = iss_done;
    assign st.pipe_idle = iss_done && !p1_v_reg;
    assign st.found = found_reg;
    assign st.range_ok = range_ok_reg;
    assign st.path_ok = pv_rd_reg;
    assign st.aug_end = aug_end;
    assign st.chain_ok = pv_rd_reg;
    assign st.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_total_flow = m_flow_reg;

    always_comb begin
        res_we = 1'b0;
        res_wa = '0;
        res_wd = '0;
        res_ra = '0;
        nd_we = 1'b0;
        nd_wa = '0;
        nd_bn_wd = '0;
        nd_par_wd = '0;
        nd_pv_wd = 1'b0;
        nd_vis_wd = 1'b0;
        nd_ra = '0;
        unique case (cmd.op)
            OP_CLEAR: begin
                res_we = !clr_reg[AW];
                res_wa = clr_reg[AW-1:0];
            end
            OP_LOAD: begin
                res_we = load_ok;
                res_wa = {NB'(s_from_node), NB'(s_to_node)};
                res_wd = RW'(CAP_BITS'(s_capacity));
            end
            OP_INIT: begin
                nd_we = !iss_done;
                nd_wa = issue_idx[NB-1:0];
                nd_bn_wd = (issue_idx[NB-1:0] == src_reg) ? BN_INF : '0;
            end
            OP_SCAN: begin
                nd_ra = issue_idx[NB-1:0];
            end
            OP_MARK: begin
                nd_we = 1'b1;
                nd_wa = best_reg;
                nd_bn_wd = best_bn_reg;
                nd_par_wd = best_par_reg;
                nd_pv_wd = best_pv_reg;
                nd_vis_wd = 1'b1;
            end
            OP_RELAX: begin
                nd_ra = issue_idx[NB-1:0];
                res_ra = {best_reg, issue_idx[NB-1:0]};
                nd_we = p1_v_reg && relax_upd;
                nd_wa = p1_idx_reg;
                nd_bn_wd = relax_w;
                nd_par_wd = best_reg;
                nd_pv_wd = 1'b1;
            end
            OP_CHK_RD: begin
                nd_ra = snk_reg;
            end
            OP_AUG_P: begin
                nd_ra = cur_reg;
            end
            OP_AUG_PW: begin
                res_ra = {par_rd_reg, cur_reg};
            end
            OP_AUG_FW: begin
                res_we = 1'b1;
                res_wa = {p_reg, cur_reg};
                res_wd = fw_new;
                res_ra = {cur_reg, p_reg};
            end
            OP_AUG_RV: begin
                res_we = 1'b1;
                res_wa = {cur_reg, p_reg};
                res_wd = rv_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (res_we) res_mem[res_wa] <= res_wd;
        res_rd_reg <= res_mem[res_ra];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) begin
            bn_mem[nd_wa] <= nd_bn_wd;
            par_mem[nd_wa] <= nd_par_wd;
            pv_mem[nd_wa] <= nd_pv_wd;
            vis_mem[nd_wa] <= nd_vis_wd;
        end
        bn_rd_reg <= bn_mem[nd_ra];
        par_rd_reg <= par_mem[nd_ra];
        pv_rd_reg <= pv_mem[nd_ra];
        vis_rd_reg <= vis_mem[nd_ra];
    end

    always_comb begin
        clr_next = clr_reg;
        idx_next = issue_idx;
        n_next = n_reg;
        src_next = src_reg;
        snk_next = snk_reg;
        range_ok_next = range_ok_reg;
        p1_v_next = issuing;
        p1_idx_next = issue_idx[NB-1:0];
        found_next = found_reg;
        best_next = best_reg;
        best_bn_next = best_bn_reg;
        best_par_next = best_par_reg;
        best_pv_next = best_pv_reg;
        f_next = f_reg;
        cur_next = cur_reg;
        p_next = p_reg;
        steps_next = steps_reg;
        total_next = total_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_flow_next = m_flow_reg;
        if (((cmd.op == OP_INIT) || (cmd.op == OP_SCAN) || (cmd.op == OP_RELAX))
                && !iss_done) begin
            idx_next = issue_idx + CW'(1);
        end
        unique case (cmd.op)
            OP_CLEAR: begin
                if (!clr_reg[AW]) clr_next = clr_reg + (AW + 1)'(1);
            end
            OP_START: begin
                n_next = n_eff;
                src_next = NB'(s_source_node);
                snk_next = NB'(s_sink_node);
                range_ok_next = (int'(s_source_node) < int'(n_eff))
                        && (int'(s_sink_node) < int'(n_eff));
                total_next = '0;
            end
            OP_SCAN: begin
                if (first) found_next = 1'b0;
                if (p1_v_reg && !vis_rd_reg && (!found_reg || (bn_rd_reg > best_bn_reg))) begin
                    found_next = 1'b1;
                    best_next = p1_idx_reg;
                    best_bn_next = bn_rd_reg;
                    best_par_next = par_rd_reg;
                    best_pv_next = pv_rd_reg;
                end
            end
            OP_CHK_EV: begin
                f_next = bn_rd_reg;
                cur_next = snk_reg;
                steps_next = '0;
            end
            OP_AUG_P: begin
                if (aug_end) total_next = flow_sat;
            end
            OP_AUG_PW: begin
                if (pv_rd_reg) begin
                    p_next = par_rd_reg;
                end else begin
                    total_next = flow_sat;
                end
            end
            OP_AUG_RV: begin
                cur_next = p_reg;
                steps_next = steps_reg + CW'(1);
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_flow_next = total_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            op_prev_reg <= OP_NONE;
            idx_reg <= '0;
            p1_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            clr_reg <= clr_next;
            op_prev_reg <= cmd.op;
            idx_reg <= idx_next;
            p1_v_reg <= p1_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
        src_reg <= src_next;
        snk_reg <= snk_next;
        range_ok_reg <= range_ok_next;
        p1_idx_reg <= p1_idx_next;
        found_reg <= found_next;
        best_reg <= best_next;
        best_bn_reg <= best_bn_next;
        best_par_reg <= best_par_next;
        best_pv_reg <= best_pv_next;
        f_reg <= f_next;
        cur_reg <= cur_next;
        p_reg <= p_next;
        steps_reg <= steps_next;
        total_reg <= total_next;
        m_flow_reg <= m_flow_next;
    end

endmodule

// ----- rtl/core/max_flow_widest_path.sv -----
// A load word is taken whenever the block is idle, and loads may follow each other in every cycle.
// A run holds the input stalled; each widest-path search makes, for n active nodes,
// one scan and one relax sweep per node through the node memory.
// Each augmenting path is walked edge by edge from the sink; after the last search the result word is registered
// once the output is free. After reset the input stays stalled for a clearing pass that zeroes all
// 2**(2*clog2(MAX_NODES)) entries (4096 at the defaults) of the capacity matrix; configuration writes are taken.
module max_flow_widest_path import mfwp_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int CAP_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [5:0]        s_from_node,
    input  logic [5:0]        s_to_node,
    input  logic [15:0]       s_capacity,
    input  logic [5:0]        s_source_node,
    input  logic [5:0]        s_sink_node,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [FLOW_W-1:0] m_total_flow
);

    logic [6:0] node_count_reg, node_count_next;
    dp_cmd_t    cmd;
    dp_status_t st;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count_reg} : 32'd0;

    always_comb begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
            node_count_next = pwdata[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
        end else begin
            node_count_reg <= node_count_next;
        end
    end

    mfwp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mfwp_datapath #(
        .MAX_NODES (MAX_NODES),
        .CAP_BITS  (CAP_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .node_count    (node_count_reg),
        .s_from_node   (s_from_node),
        .s_to_node     (s_to_node),
        .s_capacity    (s_capacity),
        .s_source_node (s_source_node),
        .s_sink_node   (s_sink_node),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_total_flow  (m_total_flow)
    );

endmodule

// ----- rtl/core/mfwp_checker.sv -----
`include "max_flow_widest_path_assert.svh"

module mfwp_checker import mfwp_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_op,
    input logic              m_valid,
    input logic              m_ready,
    input logic [FLOW_W-1:0] m_total_flow
);

    // The matrix clearing pass keeps the input stalled straight after reset.
    `MFWP_ASSERT_NEXT(a_reset_busy, aclk, 1'b0, !aresetn, !s_ready)
    `MFWP_ASSERT_NEXT(a_run_busy, aclk, !aresetn, s_valid && s_ready && s_op, !s_ready)
    `MFWP_ASSERT_NEXT(a_load_ready, aclk, !aresetn, s_valid && s_ready && !s_op, s_ready)
    `MFWP_ASSERT_NOW(a_result_after_run, aclk, !aresetn, $rose(m_valid), !$past(s_ready))
    `MFWP_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_total_flow))

endmodule

bind max_flow_widest_path mfwp_checker u_mfwp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_total_flow (m_total_flow)
);

// ----- dv/max_flow_widest_path_tb.sv -----
`timescale 1ns / 1ps

module max_flow_widest_path_tb;
    import mfwp_pkg::*;

    typedef struct {
        logic        op;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] capacity;
        logic [5:0]  source_node;
        logic [5:0]  sink_node;
    } flow_word_t;

    localparam int NODES = 64;
    localparam logic [16:0] RES_MAX = 17'h1ffff;
    localparam logic [17:0] BN_INF = 18'h20000;
    localparam logic [21:0] FLOW_MAX = 22'h3fffff;
    localparam logic [6:0] NO_PARENT = 7'h7f;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_op = 1'b0;
    logic [5:0]        s_from_node = '0;
    logic [5:0]        s_to_node = '0;
    logic [15:0]       s_capacity = '0;
    logic [5:0]        s_source_node = '0;
    logic [5:0]        s_sink_node = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [FLOW_W-1:0] m_total_flow;

    max_flow_widest_path dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    flow_word_t  word_q[$];
    logic [21:0] flow_q[$];
    logic [16:0] resid[NODES][NODES] = '{default: '0};
    logic [6:0]  node_cnt = NODE_COUNT_RST;
    int          errors = 0;
    int          results = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    bit          no_gaps = 0;

    task automatic predict_word(input flow_word_t w);
        int          n;
        int          src;
        int          snk;
        int          best;
        int          i;
        int          p;
        logic [17:0] bn[NODES];
        logic [6:0]  par[NODES];
        bit          vis[NODES];
        logic [17:0] wv;
        logic [17:0] f;
        logic [22:0] total;
        bit          found;
        if (w.op == OPC_LOAD) begin
            resid[w.from_node][w.to_node] = {1'b0, w.capacity};
            return;
        end
        n = (int'(node_cnt) > NODES) ? NODES : int'(node_cnt);
        src = int'(w.source_node);
        snk = int'(w.sink_node);
        total = '0;
        if (src < n && snk < n) begin
            found = 1;
            while (found) begin
                for (i = 0; i < n; i++) begin
                    bn[i] = '0;
                    par[i] = NO_PARENT;
                    vis[i] = 0;
                end
                bn[src] = BN_INF;
                for (int r = 0; r < n; r++) begin
                    best = n;
                    for (i = 0; i < n; i++)
                        if (!vis[i] && (best == n || bn[i] > bn[best])) best = i;
                    if (best >= n) break;
                    vis[best] = 1;
                    for (int j = 0; j < n; j++) begin
                        wv = (bn[best] < {1'b0, resid[best][j]}) ? bn[best]
                                                                 : {1'b0, resid[best][j]};
                        if (!vis[j] && resid[best][j] > 0 && bn[j] < wv) begin
                            par[j] = best[6:0];
                            bn[j] = wv;
                        end
                    end
                end
                found = (par[snk] != NO_PARENT);
                if (found) begin
                    f = bn[snk];
                    i = snk;
                    for (int s = 0; i != src && s < n; s++) begin
                        p = int'(par[i]);
                        if (p >= n) break;
                        resid[p][i] = (resid[p][i] >= f) ? resid[p][i] - f[16:0] : '0;
                        resid[i][p] = ({1'b0, RES_MAX - resid[i][p]} >= f)
                                      ? resid[i][p] + f[16:0] : RES_MAX;
                        i = p;
                    end
                    total = total + 23'(f);
                    if (total > FLOW_MAX) total = FLOW_MAX;
                end
            end
        end
        flow_q.push_back(total[21:0]);
    endtask

    always @(posedge aclk) begin
        flow_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid)
                predict_word('{s_op, s_from_node, s_to_node, s_capacity,
                               s_source_node, s_sink_node});
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                s_op <= w.op;
                s_from_node <= w.from_node;
                s_to_node <= w.to_node;
                s_capacity <= w.capacity;
                s_source_node <= w.source_node;
                s_sink_node <= w.sink_node;
                s_valid <= 1'b1;
                send_gap <= no_gaps ? 0 : $urandom_range(0, 10);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        int          stall;
        logic [21:0] want;
        stall = recv_stall;
        if (m_valid && m_ready) begin
            if (flow_q.size() == 0) begin
                $display("%0t: unexpected word, total_flow %0d", $time, m_total_flow);
                errors++;
            end else begin
                want = flow_q.pop_front();
                if (m_total_flow !== want) begin
                    $display("%0t: total_flow expected %0d, actual %0d",
                             $time, want, m_total_flow);
                    errors++;
                end
            end
            results++;
            stall = (results == 20) ? 3000 : (no_gaps ? 0 : $urandom_range(0, 10));
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall > 0) begin
            m_ready <= 1'b0;
            recv_stall <= stall - 1;
        end else begin
            m_ready <= 1'b1;
            recv_stall <= 0;
        end
    end

    function automatic flow_word_t load_word(int a, int b, int c);
        flow_word_t w;
        w.op = OPC_LOAD;
        w.from_node = 6'(a);
        w.to_node = 6'(b);
        w.capacity = 16'(c);
        w.source_node = 6'($urandom);
        w.sink_node = 6'($urandom);
        return w;
    endfunction

    function automatic flow_word_t run_word(int a, int b);
        flow_word_t w;
        w.op = OPC_RUN;
        w.from_node = 6'($urandom);
        w.to_node = 6'($urandom);
        w.capacity = 16'($urandom);
        w.source_node = 6'(a);
        w.sink_node = 6'(b);
        return w;
    endfunction

    task automatic drain_and_set(input logic [6:0] value);
        while (word_q.size() > 0 || s_valid || flow_q.size() > 0) @(negedge aclk);
        repeat (50) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_NODE_COUNT, 2'b00};
        pwdata <= {25'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        node_cnt = value;
        no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    task automatic random_phase(input int items, input int run_pct);
        int n;
        int c;
        n = (int'(node_cnt) > NODES) ? NODES : int'(node_cnt);
        for (int k = 0; k < items; k++) begin
            c = $urandom_range(0, 3);
            c = (c == 0) ? 65535 : (c == 1) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
            if ($urandom_range(0, 99) < run_pct) begin
                if ($urandom_range(0, 9) == 0)
                    word_q.push_back(run_word($urandom_range(0, 63), $urandom_range(0, 63)));
                else
                    word_q.push_back(run_word($urandom_range(0, n - 1),
                                              $urandom_range(0, n - 1)));
            end else if ($urandom_range(0, 9) == 0) begin
                word_q.push_back(load_word($urandom_range(0, 63), $urandom_range(0, 63), c));
            end else begin
                word_q.push_back(load_word($urandom_range(0, n - 1),
                                           $urandom_range(0, n - 1), c));
            end
        end
    endtask

    initial begin
        logic [6:0] sizes[$];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        word_q.push_back(load_word(0, 1, 65535));
        word_q.push_back(load_word(1, 0, 65535));
        word_q.push_back(run_word(0, 1));
        word_q.push_back(load_word(0, 1, 65535));
        word_q.push_back(run_word(0, 1));
        word_q.push_back(run_word(5, 5));
        word_q.push_back(load_word(63, 62, 65535));
        word_q.push_back(load_word(62, 0, 7));
        word_q.push_back(load_word(0, 63, 0));
        word_q.push_back(run_word(63, 0));
        word_q.push_back(run_word(0, 63));
        word_q.push_back(run_word(63, 63));
        drain_and_set(7'd3);
        word_q.push_back(load_word(0, 2, 100));
        word_q.push_back(load_word(0, 1, 40));
        word_q.push_back(load_word(1, 2, 30));
        word_q.push_back(run_word(0, 2));
        word_q.push_back(run_word(0, 40));
        word_q.push_back(run_word(40, 1));
        word_q.push_back(run_word(2, 2));
        word_q.push_back(run_word(2, 0));
        sizes = '{7'd2, 7'd5, 7'd8, 7'd4, 7'd6, 7'd3, 7'd8};
        foreach (sizes[k]) begin
            drain_and_set(sizes[k]);
            random_phase(140, 12);
        end
        drain_and_set(7'd127);
        random_phase(30, 0);
        word_q.push_back(run_word($urandom_range(0, 7), 63));
        word_q.push_back(run_word(0, $urandom_range(0, 7)));
        drain_and_set(7'd64);
        random_phase(20, 0);
        word_q.push_back(run_word(1, 62));
        drain_and_set(7'd5);
        random_phase(40, 15);
        while (word_q.size() > 0 || s_valid || flow_q.size() > 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && flow_q.size() == 0) begin
            $display("max_flow_widest_path_tb: done, clean");
        end else begin
            $display("max_flow_widest_path_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("max_flow_widest_path_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mfwp_pkg.sv
rtl/core/mfwp_ctrl.sv
rtl/core/mfwp_datapath.sv
rtl/core/max_flow_widest_path.sv
rtl/core/mfwp_checker.sv
dv/max_flow_widest_path_tb.sv
